>>> design/ngh_pkg.sv
package ngh_pkg;

  // Datapath widths
  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
  localparam int COEFF_BITS     = 16;
  localparam int THRESH_W       = 23;
  localparam int HOLD_W         = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Shared multiplier: the wider of sample magnitude and coefficient times gain
  localparam int MUL_A_W = (SAMPLE_BITS > COEFF_BITS) ? SAMPLE_BITS : COEFF_BITS;
  localparam int MUL_W   = MUL_A_W + GAIN_W;

  // Smoother sum width
  localparam int BLEND_W = COEFF_BITS + GAIN_W + 1;

  // Magnitude compare width
  localparam int CMP_W = (SAMPLE_BITS - 1 > THRESH_W) ? SAMPLE_BITS - 1 : THRESH_W;

  // Unity gain and coefficient constants
  localparam logic [GAIN_W-1:0]     GAIN_ONE  = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [COEFF_BITS:0]   COEFF_ONE = (COEFF_BITS + 1)'(1) << COEFF_BITS;
  localparam logic [BLEND_W-1:0]    BLEND_HALF = BLEND_W'(1) << (COEFF_BITS - 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GATE_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEFF   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFF  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_LENGTH    = CFG_IDX_W'(3);

  // Register reset values
  localparam logic [THRESH_W-1:0]   RST_GATE_THRESHOLD = THRESH_W'(1006633);
  localparam logic [COEFF_BITS-1:0] RST_ATTACK_COEFF   = COEFF_BITS'(65237);
  localparam logic [COEFF_BITS-1:0] RST_RELEASE_COEFF  = COEFF_BITS'(65506);
  localparam logic [HOLD_W-1:0]     RST_HOLD_LENGTH    = HOLD_W'(2400);

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GAIN,
    ST_OUT
  } state_t;

endpackage

>>> design/audio_noise_gate_hold.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  in_sample_in
// out_     output     out_valid / out_stall out_sample_out, out_gate_gain
// cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each request passes through capture, gain update and output product in turn. One
// multiplier serves both the smoother and the output scaling, so the two
// products run one after the other. Synchronous active-low reset clears gain,
// hold count, registers to defaults and the control state. A request is taken
// while a finished result still waits on out_stall; the output step then holds
// until the result register frees up. Configuration writes are always ready.
module audio_noise_gate_hold (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [ngh_pkg::SAMPLE_BITS-1:0] in_sample_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [ngh_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic        [ngh_pkg::GAIN_W-1:0]      out_gate_gain,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [ngh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [ngh_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ngh_pkg::*;

  state_t state_r, state_nxt;

  logic [THRESH_W-1:0]   gate_threshold_r;
  logic [COEFF_BITS-1:0] attack_coeff_r;
  logic [COEFF_BITS-1:0] release_coeff_r;
  logic [HOLD_W-1:0]     hold_length_r;

  logic [GAIN_W-1:0]      gain_r, gain_nxt;
  logic [HOLD_W-1:0]      hold_r, hold_nxt;
  logic [SAMPLE_BITS-1:0] true_mag_r;
  logic                   neg_r;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic [GAIN_W-1:0]             out_gain_r;

  logic                   in_accept;
  logic                   out_free;
  logic                   out_load;
  logic                   gain_step;
  logic [SAMPLE_BITS-1:0] in_raw;
  logic [SAMPLE_BITS-1:0] in_mag;

  logic [SAMPLE_BITS-2:0] sat_mag;
  logic                   gate_open;
  logic                   do_attack;
  logic [COEFF_BITS-1:0]  coeff_sel;
  logic [COEFF_BITS:0]    coeff_comp;
  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_W-1:0]       mul_p;
  logic [BLEND_W-1:0]     blend_sum;
  logic [GAIN_W-1:0]      blend_gain;
  logic [SAMPLE_BITS-1:0] prod;
  logic [SAMPLE_BITS-1:0] res;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_threshold_r <= RST_GATE_THRESHOLD;
      attack_coeff_r   <= RST_ATTACK_COEFF;
      release_coeff_r  <= RST_RELEASE_COEFF;
      hold_length_r    <= RST_HOLD_LENGTH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GATE_THRESHOLD: gate_threshold_r <= cfg_data[THRESH_W-1:0];
        REG_ATTACK_COEFF:   attack_coeff_r   <= cfg_data[COEFF_BITS-1:0];
        REG_RELEASE_COEFF:  release_coeff_r  <= cfg_data[COEFF_BITS-1:0];
        REG_HOLD_LENGTH:    hold_length_r    <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample magnitude at capture; the most negative code yields the sign bit alone
  assign in_raw = SAMPLE_BITS'(in_sample_in);
  assign in_mag = in_raw[SAMPLE_BITS-1] ? (~in_raw + SAMPLE_BITS'(1)) : in_raw;

  // Gate decision from the saturated magnitude
  assign sat_mag   = true_mag_r[SAMPLE_BITS-1] ? {(SAMPLE_BITS-1){1'b1}}
                                               : true_mag_r[SAMPLE_BITS-2:0];
  assign gate_open = CMP_W'(sat_mag) >= CMP_W'(gate_threshold_r);
  assign do_attack = gate_open && (gain_r < GAIN_ONE);
  assign coeff_sel = do_attack ? attack_coeff_r : release_coeff_r;

  // Shared multiplier: coefficient times gain, then magnitude times new gain
  assign mul_a = (state_r == ST_GAIN) ? MUL_A_W'(coeff_sel) : MUL_A_W'(true_mag_r);
  assign mul_p = MUL_W'(mul_a) * MUL_W'(gain_r);

  // Smoother: blend toward unity or zero, round half up
  assign coeff_comp = COEFF_ONE - {1'b0, coeff_sel};
  assign blend_sum  = BLEND_W'(mul_p[COEFF_BITS+GAIN_W-1:0])
                    + (gate_open ? (BLEND_W'(coeff_comp) << GAIN_FRAC_BITS) : '0)
                    + BLEND_HALF;
  assign blend_gain = blend_sum[COEFF_BITS +: GAIN_W];

  // Scaled output, truncated toward zero on the magnitude
  assign prod = mul_p[GAIN_FRAC_BITS +: SAMPLE_BITS];
  assign res  = neg_r ? (~prod + SAMPLE_BITS'(1)) : prod;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    gain_step = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        gain_step = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Gain and hold update
  always_comb begin
    gain_nxt = gain_r;
    hold_nxt = hold_r;
    if (gain_step) begin
      if (do_attack) begin
        gain_nxt = blend_gain;
        hold_nxt = '0;
      end else if (hold_r < hold_length_r) begin
        hold_nxt = hold_r + HOLD_W'(1);
      end else begin
        gain_nxt = blend_gain;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gain_r      <= '0;
      hold_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      gain_r  <= gain_nxt;
      hold_r  <= hold_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the captured sample and the result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      true_mag_r <= in_mag;
      neg_r      <= in_raw[SAMPLE_BITS-1];
    end
    if (out_load) begin
      out_sample_r <= $signed(res);
      out_gain_r   <= gain_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_gate_gain  = out_gain_r;

endmodule
